// ===== rtl/tfbs_pkg.sv =====
package tfbs_pkg;

  localparam int unsigned DefaultMaxVertices = 1024;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned NumW = 32;
  localparam int unsigned DenW = 37;
  localparam int unsigned DivSteps = 48;
  localparam int unsigned DivCntW = 6;
  localparam logic [31:0] QMax = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin = 32'h8000_0000;

  localparam logic [1:0] AlignLeft   = 2'd0;
  localparam logic [1:0] AlignRight  = 2'd1;
  localparam logic [1:0] AlignCenter = 2'd2;
  localparam logic [1:0] AlignBad    = 2'd3;

  localparam logic [CfgIdxW-1:0] RegHorizPattern = 4'd0;
  localparam logic [CfgIdxW-1:0] RegVertPattern  = 4'd1;
  localparam logic [CfgIdxW-1:0] RegAlignment    = 4'd2;
  localparam logic [CfgIdxW-1:0] RegRatioX       = 4'd3;
  localparam logic [CfgIdxW-1:0] RegRatioY       = 4'd4;
  localparam logic [CfgIdxW-1:0] RegTexWidth     = 4'd5;
  localparam logic [CfgIdxW-1:0] RegTexHeight    = 4'd6;
  localparam logic [CfgIdxW-1:0] RegTexBound     = 4'd7;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               is_last;
  } req_t;

  typedef struct packed {
    logic               error;
    logic signed [31:0] box_xmin;
    logic signed [31:0] box_ymin;
    logic signed [31:0] box_width;
    logic signed [31:0] box_height;
    logic signed [31:0] repeat_x;
    logic signed [31:0] repeat_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
  } res_t;

  typedef struct packed {
    logic signed [31:0] horiz_pattern;
    logic signed [31:0] vert_pattern;
    logic [3:0]         alignment;
    logic [23:0]        ratio_x;
    logic [23:0]        ratio_y;
    logic [12:0]        texture_width;
    logic [12:0]        texture_height;
    logic               texture_bound;
  } cfg_t;

  typedef struct packed {
    logic               err;
    logic signed [31:0] xmin;
    logic signed [31:0] xmax;
    logic signed [31:0] ymin;
    logic signed [31:0] ymax;
  } job_t;

  typedef enum logic [1:0] {
    MODE_FIT,
    MODE_VERT,
    MODE_HORIZ,
    MODE_GIVEN
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOX,
    ST_DEN0,
    ST_GO0,
    ST_WAIT0,
    ST_DEN1,
    ST_GO1,
    ST_WAIT1,
    ST_MUL0,
    ST_MUL1,
    ST_ALIGN,
    ST_OUT
  } state_e;

  // dx/dy from repeat count n (n >= 0)
  function automatic logic [31:0] align_off(input logic [1:0] code, input logic [31:0] n);
    logic [31:0] neg;
    logic signed [32:0] d;
    logic signed [32:0] h;
    neg = 32'd0 - n;
    d = 33'sh1_0000 - $signed({1'b0, n});
    h = d >>> 1;
    case (code)
      AlignRight:  align_off = {16'd0, neg[15:0]};
      AlignCenter: align_off = h[31:0];
      default:     align_off = 32'd0;
    endcase
  endfunction

  // (x * y) >> 16, saturated; x, y below 2^31
  function automatic logic [31:0] mulq(input logic [30:0] x, input logic [30:0] y);
    logic [61:0] p;
    p = x * y;
    mulq = (p[61:47] != '0) ? QMax : {1'b0, p[46:16]};
  endfunction

endpackage

// ===== rtl/tfbs_front.sv =====
module tfbs_front #(
  parameter int unsigned MaxVertices = tfbs_pkg::DefaultMaxVertices
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  tfbs_pkg::req_t req_i,
  input  logic [3:0]     alignment_i,
  output logic           push_o,
  output tfbs_pkg::job_t job_o
);
  import tfbs_pkg::*;

  localparam int unsigned CntW = $clog2(MaxVertices + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxVertices);

  logic signed [31:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic signed [31:0] xmin_d, xmax_d, ymin_d, ymax_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               bad;

  always_comb begin
    xmin_d = (req_i.vertex_x < xmin_q) ? req_i.vertex_x : xmin_q;
    xmax_d = (req_i.vertex_x > xmax_q) ? req_i.vertex_x : xmax_q;
    ymin_d = (req_i.vertex_y < ymin_q) ? req_i.vertex_y : ymin_q;
    ymax_d = (req_i.vertex_y > ymax_q) ? req_i.vertex_y : ymax_q;
    cnt_d  = (cnt_q < CntMax) ? cnt_q + 1'b1 : cnt_q;
    bad = (cnt_d <= CntW'(1)) || (cnt_d >= CntMax) ||
          (alignment_i[1:0] == AlignBad) || (alignment_i[3:2] == AlignBad);
  end

  assign push_o     = accept_i && req_i.is_last;
  assign job_o.err  = bad;
  assign job_o.xmin = xmin_d;
  assign job_o.xmax = xmax_d;
  assign job_o.ymin = ymin_d;
  assign job_o.ymax = ymax_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q <= QMax;
      ymin_q <= QMax;
      xmax_q <= QMin;
      ymax_q <= QMin;
      cnt_q  <= '0;
    end else if (accept_i) begin
      if (req_i.is_last) begin
        xmin_q <= QMax;
        ymin_q <= QMax;
        xmax_q <= QMin;
        ymax_q <= QMin;
        cnt_q  <= '0;
      end else begin
        xmin_q <= xmin_d;
        xmax_q <= xmax_d;
        ymin_q <= ymin_d;
        ymax_q <= ymax_d;
        cnt_q  <= cnt_d;
      end
    end
  end

endmodule

// ===== rtl/tfbs_queue.sv =====
module tfbs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tfbs_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output tfbs_pkg::job_t head_o
);
  import tfbs_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/tfbs_div.sv =====
module tfbs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tfbs_pkg::NumW-1:0]   num_i,
  input  logic [tfbs_pkg::DenW-1:0]   den_i,
  output logic                        done_o,
  output logic [31:0]                 quo_o
);
  import tfbs_pkg::*;

  // restoring, one quotient bit per cycle
  logic [DivSteps-1:0] sh_q;
  logic [DenW-1:0]     rem_q;
  logic [DenW-1:0]     den_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                run_q, done_q;
  logic [DenW:0]       trial;
  logic [DenW:0]       diff;
  logic                ge;

  assign trial  = {rem_q, sh_q[DivSteps-1]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = trial >= {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = (den_q == '0) ? 32'd0 :
                  (sh_q[DivSteps-1:31] != '0) ? QMax : {1'b0, sh_q[30:0]};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= {num_i, 16'd0};
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      sh_q  <= {sh_q[DivSteps-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && run_q && (cnt_q == DivCntW'(DivSteps - 1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/tfbs_back.sv =====
module tfbs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tfbs_pkg::job_t head_i,
  input  tfbs_pkg::cfg_t cfg_i,
  output logic           pop_o,
  output logic           done_o,
  output tfbs_pkg::res_t res_o
);
  import tfbs_pkg::*;

  state_e      state_q, state_d;
  job_t        job_q;
  mode_e       mode_q;
  logic [31:0] w_q, h_q, nx_q, ny_q, r0_q, p_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  res_t        res_q, res_d;
  logic        done_q;
  logic        div_start, div_done;
  logic [31:0] quo;
  logic signed [32:0] wd, hd;
  logic [31:0] w_sat, h_sat;
  logic        sel1;
  logic [12:0] tw, th;
  logic [23:0] rr;
  logic [36:0] fit_den;
  logic [31:0] pat;

  tfbs_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign wd    = {job_q.xmax[31], job_q.xmax} - {job_q.xmin[31], job_q.xmin};
  assign hd    = {job_q.ymax[31], job_q.ymax} - {job_q.ymin[31], job_q.ymin};
  assign w_sat = wd[32] ? QMax : (wd[31] ? QMax : wd[31:0]);
  assign h_sat = hd[32] ? QMax : (hd[31] ? QMax : hd[31:0]);

  assign sel1    = state_q == ST_DEN1;
  assign tw      = cfg_i.texture_width;
  assign th      = cfg_i.texture_height;
  assign rr      = sel1 ? cfg_i.ratio_y : cfg_i.ratio_x;
  assign fit_den = rr * (sel1 ? th : tw);
  assign pat     = (mode_q == MODE_VERT) ? cfg_i.vert_pattern : cfg_i.horiz_pattern;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (!empty_i) state_d = ST_BOX;
      ST_BOX: begin
        if (job_q.err || !cfg_i.texture_bound) begin
          state_d = ST_OUT;
        end else if (cfg_i.horiz_pattern > 0 && cfg_i.vert_pattern > 0) begin
          state_d = ST_ALIGN;
        end else if (cfg_i.horiz_pattern <= 0 && cfg_i.vert_pattern <= 0) begin
          state_d = ST_DEN0;
        end else if (cfg_i.horiz_pattern <= 0) begin
          state_d = (h_sat == '0) ? ST_ALIGN : ST_DEN0;
        end else begin
          state_d = (w_sat == '0) ? ST_ALIGN : ST_DEN0;
        end
      end
      ST_DEN0:  state_d = ST_GO0;
      ST_GO0:   state_d = ST_WAIT0;
      ST_WAIT0: if (div_done) state_d = ST_DEN1;
      ST_DEN1:  state_d = ST_GO1;
      ST_GO1:   state_d = ST_WAIT1;
      ST_WAIT1: if (div_done) state_d = (mode_q == MODE_FIT) ? ST_ALIGN : ST_MUL0;
      ST_MUL0:  state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_ALIGN;
      ST_ALIGN: state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = (state_q == ST_IDLE) && !empty_i;
    div_start = (state_q == ST_GO0) || (state_q == ST_GO1);
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: job_q <= head_i;
      ST_BOX: begin
        w_q  <= w_sat;
        h_q  <= h_sat;
        if (cfg_i.horiz_pattern > 0 && cfg_i.vert_pattern > 0) begin
          mode_q <= MODE_GIVEN;
          nx_q   <= cfg_i.horiz_pattern;
          ny_q   <= cfg_i.vert_pattern;
        end else begin
          nx_q <= '0;
          ny_q <= '0;
          if (cfg_i.horiz_pattern <= 0 && cfg_i.vert_pattern <= 0) begin
            mode_q <= MODE_FIT;
          end else if (cfg_i.horiz_pattern <= 0) begin
            mode_q <= MODE_VERT;
          end else begin
            mode_q <= MODE_HORIZ;
          end
        end
      end
      ST_DEN0, ST_DEN1: begin
        case (mode_q)
          MODE_FIT: begin
            num_q <= sel1 ? h_q : w_q;
            den_q <= fit_den;
          end
          MODE_VERT: begin
            num_q <= sel1 ? w_q : {19'd0, th};
            den_q <= sel1 ? {5'd0, h_q} : {24'd0, tw};
          end
          default: begin
            num_q <= sel1 ? h_q : {19'd0, tw};
            den_q <= sel1 ? {5'd0, w_q} : {24'd0, th};
          end
        endcase
      end
      ST_WAIT0: if (div_done) r0_q <= quo;
      ST_WAIT1: begin
        if (div_done) begin
          if (mode_q == MODE_FIT) begin
            nx_q <= r0_q;
            ny_q <= quo;
          end else begin
            nx_q <= quo;
          end
        end
      end
      ST_MUL0: p_q <= mulq(pat[30:0], r0_q[30:0]);
      ST_MUL1: begin
        if (mode_q == MODE_VERT) begin
          nx_q <= mulq(p_q[30:0], nx_q[30:0]);
          ny_q <= cfg_i.vert_pattern;
        end else begin
          ny_q <= mulq(p_q[30:0], nx_q[30:0]);
          nx_q <= cfg_i.horiz_pattern;
        end
      end
      ST_ALIGN: begin
        r0_q <= align_off(cfg_i.alignment[1:0], nx_q);
        p_q  <= align_off(cfg_i.alignment[3:2], ny_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == ST_OUT;
    end
  end

  always_comb begin
    res_d = '0;
    if (job_q.err) begin
      res_d.error = 1'b1;
    end else begin
      res_d.box_xmin   = job_q.xmin;
      res_d.box_ymin   = job_q.ymin;
      res_d.box_width  = w_sat;
      res_d.box_height = h_sat;
      if (cfg_i.texture_bound) begin
        res_d.repeat_x = nx_q;
        res_d.repeat_y = ny_q;
        res_d.offset_x = r0_q;
        res_d.offset_y = p_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/texture_fit_bbox_setup_top.sv =====
// Channel   Signals                                   Handshake
// vertex    start, busy, req_i                        taken when start && !busy
// config    cfg_valid_i, cfg_ready_o, cfg_index_i,    taken when valid && ready
//           cfg_data_i
// result    done_o, res_o                             one-cycle strobe, no backpressure
// Vertices are taken one per cycle while busy is low. Fitted and aspect modes run two
// 48-step serial divisions, the aspect modes then two multiply states; given patterns or
// a zero box side go straight to alignment, and an error or no texture straight to the
// result. A two-entry queue sits between front and back; busy is high while it is full.
// Reset restarts the running box, empties the queue and resets the config registers.
module texture_fit_bbox_setup_top #(
  parameter int unsigned MaxVertices = tfbs_pkg::DefaultMaxVertices
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  tfbs_pkg::req_t               req_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tfbs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output logic                         done_o,
  output tfbs_pkg::res_t               res_o
);
  import tfbs_pkg::*;

  cfg_t cfg_q;
  logic accept, push, full, empty, pop;
  job_t job, head;

  assign busy        = full;
  assign accept      = start && !full;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.horiz_pattern  <= '0;
      cfg_q.vert_pattern   <= '0;
      cfg_q.alignment      <= 4'd10;
      cfg_q.ratio_x        <= 24'h01_0000;
      cfg_q.ratio_y        <= 24'h01_0000;
      cfg_q.texture_width  <= '0;
      cfg_q.texture_height <= '0;
      cfg_q.texture_bound  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegHorizPattern: cfg_q.horiz_pattern  <= cfg_data_i;
        RegVertPattern:  cfg_q.vert_pattern   <= cfg_data_i;
        RegAlignment:    cfg_q.alignment      <= cfg_data_i[3:0];
        RegRatioX:       cfg_q.ratio_x        <= cfg_data_i[23:0];
        RegRatioY:       cfg_q.ratio_y        <= cfg_data_i[23:0];
        RegTexWidth:     cfg_q.texture_width  <= cfg_data_i[12:0];
        RegTexHeight:    cfg_q.texture_height <= cfg_data_i[12:0];
        RegTexBound:     cfg_q.texture_bound  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tfbs_front #(.MaxVertices(MaxVertices)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i    (accept),
    .req_i,
    .alignment_i (cfg_q.alignment),
    .push_o      (push),
    .job_o       (job)
  );

  tfbs_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  tfbs_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .head_i  (head),
    .cfg_i   (cfg_q),
    .pop_o   (pop),
    .done_o,
    .res_o
  );

endmodule
